/* sv/ukf_pkg.sv */
// ukf_pkg: shared types, op and status codes for the unique-key queue
// no dependencies; compiled first
package ukf_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int ID_W     = 16;
    localparam int RES_W    = 16;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 5;

    localparam logic [OP_W-1:0] OP_ENQUEUE  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE  = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK     = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd3;
    localparam logic [OP_W-1:0] OP_CONTAINS = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [RES_W-1:0] resource;
    } entry_t;

endpackage

/* sv/ukf_req_if.sv */
// ukf_req_if: request channel, valid/ready plus one request beat
// depends on ukf_pkg
interface ukf_req_if;
    logic                        valid;
    logic                        ready;
    logic [ukf_pkg::OP_W-1:0]    op;
    logic [ukf_pkg::ID_W-1:0]    entry_id;
    logic [ukf_pkg::RES_W-1:0]   entry_resource;

    modport source (output valid, output op, output entry_id, output entry_resource,
                    input ready);
    modport sink   (input valid, input op, input entry_id, input entry_resource,
                    output ready);
endinterface

/* sv/ukf_rsp_if.sv */
// ukf_rsp_if: response channel, valid/ready plus one result beat
// depends on ukf_pkg
interface ukf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ukf_pkg::STATUS_W-1:0]  status;
    logic                          found;
    logic [ukf_pkg::ID_W-1:0]      head_id;
    logic [ukf_pkg::RES_W-1:0]     head_resource;
    logic [ukf_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, output status, output found, output head_id,
                    output head_resource, output occupancy, input ready);
    modport sink   (input valid, input status, input found, input head_id,
                    input head_resource, input occupancy, output ready);
endinterface

/* sv/unique_key_fifo_with_removal_core.sv */
// unique_key_fifo_with_removal_core: ordered queue of unique ids with removal by id
// depends on ukf_pkg, ukf_req_if, ukf_rsp_if, ukf_store
//
// usage
//   req carries one operation per beat: enqueue, dequeue, peek, remove by id or
//   contains. rsp returns exactly one result beat per request, in order.
//   entries live in a memory in queue order, slot 0 the head. a sequencer walks
//   that memory through its single read port: a scan compares one stored id per
//   cycle, and closing a gap moves one entry per cycle (read ahead, write behind).
//   steps, by op:
//     rejected/invalid ops and empty dequeue/peek : straight to the result register
//     peek                                      : head read
//     enqueue, contains                         : scan of the queued ids
//     remove                                    : scan, then shift
//     dequeue                                   : head read, then shift
//   one request is in flight at a time; req.ready is high only while idle, so a
//   new request is taken only once the sequencer is through with the last one.
//   the result register decouples rsp: a new request is taken while the last
//   result still waits, and a finished result waits for rsp.ready, while the last
//   one is still held, before the sequencer goes idle again.
//   reset empties the queue and drops any pending result; memory content is not
//   cleared since only slots below the fill count are ever used.
module unique_key_fifo_with_removal_core #(
    parameter int DEPTH = ukf_pkg::DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    ukf_req_if.sink      req,
    ukf_rsp_if.source    rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [ukf_pkg::OP_W-1:0]      op_reg, op_next;
    logic [ukf_pkg::ID_W-1:0]      id_reg, id_next;
    logic [ukf_pkg::RES_W-1:0]     res_reg, res_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 wr_idx_reg, wr_idx_next;
    logic                          pend_reg, pend_next;
    logic [ukf_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                          found_reg, found_next;
    ukf_pkg::entry_t               head_reg, head_next;

    logic                          out_valid_reg, out_valid_next;
    logic [ukf_pkg::STATUS_W-1:0]  out_status_reg;
    logic                          out_found_reg;
    ukf_pkg::entry_t               out_head_reg;
    logic [ukf_pkg::OCC_W-1:0]     out_occ_reg;
    logic                          out_load;

    logic                          mem_wr_en;
    logic [AW-1:0]                 mem_wr_addr;
    ukf_pkg::entry_t               mem_wr_data;
    logic [AW-1:0]                 mem_rd_addr;
    ukf_pkg::entry_t               mem_rd_data;

    logic                          hit;

    ukf_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign hit = pend_reg && (mem_rd_data.id == id_reg);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        res_next    = res_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        wr_idx_next = wr_idx_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        found_next  = found_reg;
        head_next   = head_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = wr_idx_reg[AW-1:0];
        mem_wr_data = mem_rd_data;
        mem_rd_addr = idx_reg[AW-1:0];
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    id_next     = req.entry_id;
                    res_next    = req.entry_resource;
                    status_next = ukf_pkg::ST_OK;
                    found_next  = 1'b0;
                    head_next   = '0;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    case (req.op) inside
                        ukf_pkg::OP_ENQUEUE:
                        begin
                            if (req.entry_id == '0 || req.entry_resource == '0)
                            begin
                                status_next = ukf_pkg::ST_INVALID;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ukf_pkg::OP_DEQUEUE, ukf_pkg::OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ukf_pkg::ST_EMPTY;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_HEAD;
                            end
                        end
                        ukf_pkg::OP_REMOVE:
                        begin
                            state_next = S_SCAN;
                        end
                        ukf_pkg::OP_CONTAINS:
                        begin
                            state_next = (req.entry_id == '0) ? S_FIN : S_SCAN;
                        end
                        default:
                        begin
                            status_next = ukf_pkg::ST_INVALID;
                            state_next  = S_FIN;
                        end
                    endcase
                end
            end

            S_HEAD:
            begin
                mem_rd_addr = '0;
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    head_next = mem_rd_data;
                    pend_next = 1'b0;
                    if (op_reg == ukf_pkg::OP_PEEK)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next    = CW'(1);
                        wr_idx_next = '0;
                        state_next  = S_SHIFT;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    pend_next = 1'b0;
                    case (op_reg)
                        ukf_pkg::OP_ENQUEUE:
                        begin
                            status_next = ukf_pkg::ST_DUPLICATE;
                            state_next  = S_FIN;
                        end
                        ukf_pkg::OP_REMOVE:
                        begin
                            // idx already points past the match: shift starts there
                            wr_idx_next = idx_reg - CW'(1);
                            state_next  = S_SHIFT;
                        end
                        default:
                        begin
                            found_next = 1'b1;
                            state_next = S_FIN;
                        end
                    endcase
                end
                else if (idx_reg == count_reg)
                begin
                    pend_next = 1'b0;
                    state_next = S_FIN;
                    case (op_reg)
                        ukf_pkg::OP_ENQUEUE:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ukf_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en          = 1'b1;
                                mem_wr_addr        = count_reg[AW-1:0];
                                mem_wr_data.id       = id_reg;
                                mem_wr_data.resource = res_reg;
                                count_next         = count_reg + CW'(1);
                            end
                        end
                        ukf_pkg::OP_REMOVE:
                        begin
                            status_next = ukf_pkg::ST_NOT_FOUND;
                        end
                        default:
                        begin
                            found_next = 1'b0;
                        end
                    endcase
                end
                else
                begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
            end

            S_SHIFT:
            begin
                // read slot idx, write the previous beat one slot lower
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    wr_idx_next = wr_idx_reg + CW'(1);
                end
                if (idx_reg < count_reg)
                begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            wr_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            wr_idx_reg    <= wr_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        head_reg   <= head_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_found_reg  <= found_reg;
            out_head_reg   <= head_reg;
            out_occ_reg    <= ukf_pkg::OCC_W'(count_reg);
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.head_id       = out_head_reg.id;
    assign rsp.head_resource = out_head_reg.resource;
    assign rsp.occupancy     = out_occ_reg;

endmodule

/* sv/ukf_store.sv */
// ukf_store: entry memory, one write port and one registered read port
// depends on ukf_pkg (entry_t)
module ukf_store #(
    parameter int DEPTH = ukf_pkg::DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  ukf_pkg::entry_t           wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output ukf_pkg::entry_t           rd_data
);

    ukf_pkg::entry_t mem [DEPTH];
    ukf_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/ukf_checker.sv */
// ukf_checker: port-level checks on the unique-key queue, bound to the core
// depends on ukf_pkg and unique_key_fifo_with_removal_core
module ukf_checker #(
    parameter int DEPTH = ukf_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [ukf_pkg::STATUS_W-1:0]  status,
    input  logic                          found,
    input  logic [ukf_pkg::ID_W-1:0]      head_id,
    input  logic [ukf_pkg::RES_W-1:0]     head_resource,
    input  logic [ukf_pkg::OCC_W-1:0]     occupancy
);

    // one request in flight: ready drops right after a request beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one still in flight");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ukf_pkg::ST_EMPTY
            |-> head_id == '0 && head_resource == '0 && occupancy == '0)
        else $error("empty result with nonzero head or occupancy");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ukf_pkg::ST_OK && head_id == '0)
        else $error("found flag on a non-contains or failed result");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 31) || (int'(occupancy) <= DEPTH))
        else $error("occupancy beyond queue depth");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
        else $error("stalled result beat changed");

endmodule

bind unique_key_fifo_with_removal_core ukf_checker #(
    .DEPTH (DEPTH)
) u_ukf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .found         (rsp.found),
    .head_id       (rsp.head_id),
    .head_resource (rsp.head_resource),
    .occupancy     (rsp.occupancy)
);
